// File: hdl/htba_pkg.sv
// ----------------------------------------------------------------------------
// htba_pkg
// Shared sizes, kind codes and the store write bundle for the handle table
// ----------------------------------------------------------------------------
package htba_pkg;

    localparam int TABLE_SIZE     = 16;
    localparam int SLOT_W         = $clog2(TABLE_SIZE);
    localparam int RESERVED_SLOTS = 3;
    localparam int OH_W           = 16;
    localparam int CNT_W          = 16;

    typedef logic [SLOT_W-1:0] slot_idx_t;

    localparam slot_idx_t SLOT_LAST   = SLOT_W'(TABLE_SIZE - 1);
    localparam slot_idx_t SWEEP_FIRST = SLOT_W'(RESERVED_SLOTS);

    localparam logic [2:0] KIND_OPEN   = 3'd0;
    localparam logic [2:0] KIND_CLOSE  = 3'd1;
    localparam logic [2:0] KIND_LOOKUP = 3'd2;
    localparam logic [2:0] KIND_ADD    = 3'd3;
    localparam logic [2:0] KIND_REMOVE = 3'd4;

    localparam logic signed [OH_W:0] OUTER_FAIL = -(OH_W+1)'(1);

    typedef struct packed {
        logic             en;
        slot_idx_t        addr;
        logic [OH_W-1:0]  data;
    } store_wr_t;

endpackage

// File: hdl/htba_store.sv
// ----------------------------------------------------------------------------
// htba_store
// Outer handle memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module htba_store
    import htba_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  store_wr_t       wr,
    input  slot_idx_t       rd_addr,
    output logic [OH_W-1:0] rd_data
);

    logic [OH_W-1:0]           mem [TABLE_SIZE];
    logic [OH_W-1:0]           mem_q_reg;
    slot_idx_t                 rd_addr_reg;
    logic                      preset_hit_reg;
    logic                      preset_hit;
    logic [RESERVED_SLOTS-1:0] preset_reg;

    // reserved entries read as their own index until first written
    always_comb
    begin
        preset_hit = 1'b0;
        for (int i = 0; i < RESERVED_SLOTS; i++)
        begin
            if (rd_addr == SLOT_W'(i) && preset_reg[i])
            begin
                preset_hit = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        mem_q_reg      <= mem[rd_addr];
        rd_addr_reg    <= rd_addr;
        preset_hit_reg <= preset_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preset_reg <= '1;
        end
        else
        begin
            for (int i = 0; i < RESERVED_SLOTS; i++)
            begin
                if (wr.en && wr.addr == SLOT_W'(i))
                begin
                    preset_reg[i] <= 1'b0;
                end
            end
        end
    end

    assign rd_data = preset_hit_reg ? OH_W'(rd_addr_reg) : mem_q_reg;

endmodule

// File: hdl/handle_table_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// handle_table_bitmap_allocator
// Handle table with a free bitmap, a user count and a release sweep
// ----------------------------------------------------------------------------
// channel   handshake                  payload
// command   start, busy (in: start&!busy)  kind, handle, outer_handle
// result    result_valid (1 cycle)     status, slot, outer_handle_out,
//                                      released, no_users, last
//
// close, add user, unknown kinds, lookup misses and remove user unless it ends
// the last user: result the cycle after the transaction, busy stays low.
// lookup hit: result through the registered store read. open: one bitmap slot
// tested per cycle by the scan pointer. sweep: one slot per cycle from slot 3,
// then a drain state and a final state. reset restores the bitmap and count at
// once, no clearing pass. the result side cannot stall.
// ----------------------------------------------------------------------------
module handle_table_bitmap_allocator
    import htba_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [2:0]             kind,
    input  logic [7:0]             handle,
    input  logic [OH_W-1:0]        outer_handle,
    output logic                   result_valid,
    output logic                   status,
    output logic [7:0]             slot,
    output logic signed [OH_W:0]   outer_handle_out,
    output logic                   released,
    output logic                   no_users,
    output logic                   last
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_LOOK  = 6'b000100,
        ST_SWEEP = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_FINAL = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    slot_idx_t              ptr_reg, ptr_next;
    logic                   pend_reg, pend_next;
    slot_idx_t              pend_slot_reg, pend_slot_next;
    logic [TABLE_SIZE-1:0]  used_reg, used_next;
    logic [CNT_W-1:0]       uc_reg, uc_next;
    logic [7:0]             h_reg, h_next;
    logic [OH_W-1:0]        oh_reg, oh_next;

    logic                   valid_reg;
    logic                   status_reg;
    logic [7:0]             slot_reg;
    logic signed [OH_W:0]   oh_out_reg;
    logic                   rel_reg;
    logic                   nu_reg;
    logic                   last_reg;

    store_wr_t              wr;
    slot_idx_t              rd_addr;
    logic [OH_W-1:0]        rd_data;

    logic                   emit;
    logic                   e_status;
    logic [7:0]             e_slot;
    logic signed [OH_W:0]   e_oh;
    logic                   e_rel;
    logic                   e_last;
    logic                   hit_open;
    slot_idx_t              hidx;

    htba_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign hidx     = handle[SLOT_W-1:0];
    assign hit_open = ({1'b0, handle} < 9'(TABLE_SIZE)) && used_reg[hidx];

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        pend_slot_next = pend_slot_reg;
        used_next      = used_reg;
        uc_next        = uc_reg;
        h_next         = h_reg;
        oh_next        = oh_reg;
        wr             = '0;
        rd_addr        = ptr_reg;
        emit           = 1'b0;
        e_status       = 1'b0;
        e_slot         = '0;
        e_oh           = '0;
        e_rel          = 1'b0;
        e_last         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                rd_addr = hidx;
                if (start)
                begin
                    h_next  = handle;
                    oh_next = outer_handle;
                    unique case (kind)
                        KIND_OPEN:
                        begin
                            ptr_next   = '0;
                            state_next = ST_SCAN;
                        end
                        KIND_CLOSE:
                        begin
                            emit   = 1'b1;
                            e_last = 1'b1;
                            e_slot = handle;
                            if (hit_open)
                            begin
                                used_next[hidx] = 1'b0;
                            end
                            else
                            begin
                                e_status = 1'b1;
                                e_oh     = OUTER_FAIL;
                            end
                        end
                        KIND_LOOKUP:
                        begin
                            if (hit_open)
                            begin
                                state_next = ST_LOOK;
                            end
                            else
                            begin
                                emit     = 1'b1;
                                e_last   = 1'b1;
                                e_slot   = handle;
                                e_status = 1'b1;
                                e_oh     = OUTER_FAIL;
                            end
                        end
                        KIND_ADD:
                        begin
                            emit   = 1'b1;
                            e_last = 1'b1;
                            if (uc_reg == '1)
                            begin
                                e_status = 1'b1;
                                e_oh     = OUTER_FAIL;
                            end
                            else
                            begin
                                uc_next = uc_reg + 1'b1;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (uc_reg == '0)
                            begin
                                emit     = 1'b1;
                                e_last   = 1'b1;
                                e_status = 1'b1;
                                e_oh     = OUTER_FAIL;
                            end
                            else
                            begin
                                uc_next = uc_reg - 1'b1;
                                if (uc_reg == CNT_W'(1))
                                begin
                                    ptr_next   = SWEEP_FIRST;
                                    pend_next  = 1'b0;
                                    state_next = ST_SWEEP;
                                end
                                else
                                begin
                                    emit   = 1'b1;
                                    e_last = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            emit     = 1'b1;
                            e_last   = 1'b1;
                            e_status = 1'b1;
                            e_oh     = OUTER_FAIL;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (!used_reg[ptr_reg])
                begin
                    used_next[ptr_reg] = 1'b1;
                    wr.en      = 1'b1;
                    wr.addr    = ptr_reg;
                    wr.data    = oh_reg;
                    emit       = 1'b1;
                    e_last     = 1'b1;
                    e_slot     = 8'(ptr_reg);
                    e_oh       = signed'({1'b0, oh_reg});
                    state_next = ST_IDLE;
                end
                else if (ptr_reg == SLOT_LAST)
                begin
                    emit       = 1'b1;
                    e_last     = 1'b1;
                    e_status   = 1'b1;
                    e_oh       = OUTER_FAIL;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_LOOK:
            begin
                emit       = 1'b1;
                e_last     = 1'b1;
                e_slot     = h_reg;
                e_oh       = signed'({1'b0, rd_data});
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                // store data comes from the registered read of the previous pointer
                if (pend_reg)
                begin
                    emit  = 1'b1;
                    e_rel = 1'b1;
                    e_slot = 8'(pend_slot_reg);
                    e_oh   = signed'({1'b0, rd_data});
                end
                if (used_reg[ptr_reg])
                begin
                    used_next[ptr_reg] = 1'b0;
                    pend_next          = 1'b1;
                    pend_slot_next     = ptr_reg;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (ptr_reg == SLOT_LAST)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (pend_reg)
                begin
                    emit   = 1'b1;
                    e_rel  = 1'b1;
                    e_slot = 8'(pend_slot_reg);
                    e_oh   = signed'({1'b0, rd_data});
                end
                pend_next  = 1'b0;
                state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                emit       = 1'b1;
                e_last     = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ptr_reg   <= '0;
            pend_reg  <= 1'b0;
            used_reg  <= TABLE_SIZE'((1 << RESERVED_SLOTS) - 1);
            uc_reg    <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            pend_reg  <= pend_next;
            used_reg  <= used_next;
            uc_reg    <= uc_next;
            valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_slot_reg <= pend_slot_next;
        h_reg         <= h_next;
        oh_reg        <= oh_next;
        if (emit)
        begin
            status_reg <= e_status;
            slot_reg   <= e_slot;
            oh_out_reg <= e_oh;
            rel_reg    <= e_rel;
            nu_reg     <= (uc_next == '0);
            last_reg   <= e_last;
        end
    end

    assign busy             = (state_reg != ST_IDLE);
    assign result_valid     = valid_reg;
    assign status           = status_reg;
    assign slot             = slot_reg;
    assign outer_handle_out = oh_out_reg;
    assign released         = rel_reg;
    assign no_users         = nu_reg;
    assign last             = last_reg;

`ifndef ASSERT_OFF
    a_sweep_no_users: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (uc_reg == '0))
        else $error("sweep running with users left");

    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINAL) |=> (valid_reg && last_reg && !rel_reg))
        else $error("sweep did not end with a final result");

    a_released_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && rel_reg) |-> (!last_reg && !status_reg && nu_reg))
        else $error("released result malformed");

    a_quick_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_CLOSE || kind == KIND_ADD))
        |=> (valid_reg && last_reg && !busy))
        else $error("single cycle transaction did not complete");

    a_scan_no_write_reserved_preset: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> !used_reg[wr.addr])
        else $error("store write to a slot in use");
`endif

endmodule

// File: tb/tb_handle_table_bitmap_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_handle_table_bitmap_allocator
// Self-checking bench for the handle table: a queue-fed command driver, a
// result monitor and an in-bench model of the slot bitmap, stored handles and
// user count. Directed table-full, out-of-range, reserved-slot and sweep
// cases come first, then random traffic with idle bursts, then a short
// add-user/remove-user run with one more remove than add.
// ----------------------------------------------------------------------------
module tb_handle_table_bitmap_allocator;
    import htba_pkg::*;

    localparam logic [2:0] KIND_BAD_FIRST = 3'd5;
    localparam logic [2:0] KIND_BAD_LAST  = 3'd7;
    localparam int         WATCH_LIMIT    = 500;
    localparam int         DRAIN_CYCLES   = 40;
    localparam int         RESET_CYCLES   = 11;

    typedef struct {
        logic [2:0]      kind;
        logic [7:0]      handle;
        logic [OH_W-1:0] outer;
    } cmd_t;

    typedef struct {
        logic                 status;
        logic [7:0]           slot;
        logic signed [OH_W:0] outer;
        logic                 released;
        logic                 no_users;
        logic                 last;
    } table_result_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [2:0]           kind = KIND_OPEN;
    logic [7:0]           handle = 8'd0;
    logic [OH_W-1:0]      outer_handle = '0;
    logic                 result_valid;
    logic                 status;
    logic [7:0]           slot;
    logic signed [OH_W:0] outer_handle_out;
    logic                 released;
    logic                 no_users;
    logic                 last;

    cmd_t          cmd_q[$];
    table_result_t expected_q[$];
    cmd_t          cur_cmd;

    logic [TABLE_SIZE-1:0] open_slots;
    logic [OH_W-1:0]       stored_outer[TABLE_SIZE];
    logic [CNT_W-1:0]      user_cnt;

    int unsigned n_sent;
    int unsigned n_taken = 0;
    int unsigned err_cnt = 0;
    int          idle_left;
    int          stall_cnt;
    bit          idle_en;

    handle_table_bitmap_allocator uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .kind             (kind),
        .handle           (handle),
        .outer_handle     (outer_handle),
        .result_valid     (result_valid),
        .status           (status),
        .slot             (slot),
        .outer_handle_out (outer_handle_out),
        .released         (released),
        .no_users         (no_users),
        .last             (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void table_reset();
        open_slots = '0;
        for (int i = 0; i < TABLE_SIZE; i++)
            stored_outer[i] = '0;
        for (int i = 0; i < RESERVED_SLOTS; i++)
        begin
            open_slots[i]   = 1'b1;
            stored_outer[i] = OH_W'(i);
        end
        user_cnt = '0;
    endfunction

    function automatic void expect_result(input logic st, input logic [7:0] sl,
                                          input logic signed [OH_W:0] o,
                                          input logic rel, input logic lst);
        table_result_t r;
        r.status   = st;
        r.slot     = sl;
        r.outer    = o;
        r.released = rel;
        r.no_users = (user_cnt == '0);
        r.last     = lst;
        expected_q.push_back(r);
    endfunction

    // table update and expected results for one accepted transaction
    function automatic void table_apply(input cmd_t c);
        logic hit;
        logic found;
        hit   = 1'b0;
        found = 1'b0;
        if (c.handle < TABLE_SIZE)
            hit = open_slots[c.handle[SLOT_W-1:0]];
        case (c.kind)
            KIND_OPEN:
            begin
                for (int i = 0; i < TABLE_SIZE; i++)
                begin
                    if (!found && !open_slots[i])
                    begin
                        found           = 1'b1;
                        open_slots[i]   = 1'b1;
                        stored_outer[i] = c.outer;
                        expect_result(1'b0, 8'(i), {1'b0, c.outer}, 1'b0, 1'b1);
                    end
                end
                if (!found)
                    expect_result(1'b1, 8'd0, OUTER_FAIL, 1'b0, 1'b1);
            end
            KIND_CLOSE:
            begin
                if (!hit)
                    expect_result(1'b1, c.handle, OUTER_FAIL, 1'b0, 1'b1);
                else
                begin
                    open_slots[c.handle[SLOT_W-1:0]] = 1'b0;
                    expect_result(1'b0, c.handle, '0, 1'b0, 1'b1);
                end
            end
            KIND_LOOKUP:
            begin
                if (!hit)
                    expect_result(1'b1, c.handle, OUTER_FAIL, 1'b0, 1'b1);
                else
                    expect_result(1'b0, c.handle,
                                  {1'b0, stored_outer[c.handle[SLOT_W-1:0]]}, 1'b0, 1'b1);
            end
            KIND_ADD:
            begin
                if (user_cnt == '1)
                    expect_result(1'b1, 8'd0, OUTER_FAIL, 1'b0, 1'b1);
                else
                begin
                    user_cnt = user_cnt + 1'b1;
                    expect_result(1'b0, 8'd0, '0, 1'b0, 1'b1);
                end
            end
            KIND_REMOVE:
            begin
                if (user_cnt == '0)
                    expect_result(1'b1, 8'd0, OUTER_FAIL, 1'b0, 1'b1);
                else
                begin
                    user_cnt = user_cnt - 1'b1;
                    if (user_cnt == '0)
                    begin
                        for (int i = RESERVED_SLOTS; i < TABLE_SIZE; i++)
                        begin
                            if (open_slots[i])
                            begin
                                open_slots[i] = 1'b0;
                                expect_result(1'b0, 8'(i), {1'b0, stored_outer[i]},
                                              1'b1, 1'b0);
                            end
                        end
                    end
                    expect_result(1'b0, 8'd0, '0, 1'b0, 1'b1);
                end
            end
            default:
                expect_result(1'b1, 8'd0, OUTER_FAIL, 1'b0, 1'b1);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic send_cmd(input logic [2:0] k, input logic [7:0] h,
                            input logic [OH_W-1:0] o);
        cmd_t c;
        while (cmd_q.size() >= 2)
            @(posedge clk);
        c.kind   = k;
        c.handle = h;
        c.outer  = o;
        cmd_q.push_back(c);
        n_sent++;
    endtask

    // mostly open slots, some free or out-of-range ones
    function automatic logic [7:0] pick_handle();
        int r;
        int base;
        r    = $urandom_range(0, 9);
        base = $urandom_range(0, TABLE_SIZE - 1);
        if (r == 9)
            return 8'($urandom_range(0, 255));
        if (r < 7)
        begin
            for (int i = 0; i < TABLE_SIZE; i++)
                if (open_slots[(base + i) % TABLE_SIZE])
                    return 8'((base + i) % TABLE_SIZE);
        end
        return 8'(base);
    endfunction

    task automatic send_random_cmd();
        int              r;
        logic [7:0]      h;
        logic [OH_W-1:0] o;
        r = $urandom_range(0, 99);
        h = pick_handle();
        o = OH_W'($urandom);
        if (r < 30)
            send_cmd(KIND_OPEN, 8'($urandom), o);
        else if (r < 50)
            send_cmd(KIND_CLOSE, h, o);
        else if (r < 70)
            send_cmd(KIND_LOOKUP, h, o);
        else if (r < 82)
            send_cmd(KIND_ADD, h, o);
        else if (r < 94)
            send_cmd(KIND_REMOVE, h, o);
        else
            send_cmd(3'($urandom_range(KIND_BAD_FIRST, KIND_BAD_LAST)), h, o);
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start        <= 1'b0;
            kind         <= KIND_OPEN;
            handle       <= 8'd0;
            outer_handle <= '0;
            idle_left    = 0;
            table_reset();
        end
        else
        begin
            if (start && !busy)
            begin
                table_apply(cur_cmd);
                n_taken++;
            end
            if (!start || !busy)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    start <= 1'b0;
                end
                else if (cmd_q.size() == 0)
                    start <= 1'b0;
                else if (idle_en && $urandom_range(0, 3) == 0)
                begin
                    idle_left = $urandom_range(0, 3);
                    start     <= 1'b0;
                end
                else
                begin
                    cur_cmd      = cmd_q.pop_front();
                    kind         <= cur_cmd.kind;
                    handle       <= cur_cmd.handle;
                    outer_handle <= cur_cmd.outer;
                    start        <= 1'b1;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && result_valid)
        begin
            if (expected_q.size() == 0)
                report_mismatch($sformatf("unexpected result: slot %0d last %0b",
                                          slot, last));
            else
            begin
                want = expected_q.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status got %b want %b",
                                              status, want.status));
                if (slot !== want.slot)
                    report_mismatch($sformatf("slot got %0d want %0d", slot, want.slot));
                if (outer_handle_out !== want.outer)
                    report_mismatch($sformatf("outer handle got %0d want %0d",
                                              outer_handle_out, want.outer));
                if (released !== want.released)
                    report_mismatch($sformatf("released got %b want %b",
                                              released, want.released));
                if (no_users !== want.no_users)
                    report_mismatch($sformatf("no_users got %b want %b",
                                              no_users, want.no_users));
                if (last !== want.last)
                    report_mismatch($sformatf("last got %b want %b", last, want.last));
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n)
            stall_cnt = 0;
        else
        begin
            if ((start && !busy) || result_valid)
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= WATCH_LIMIT)
            begin
                $display("handle_table_bitmap_allocator: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        n_sent    = 0;
        idle_en   = 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // fill the table, overflow it, probe edges, then sweep all but the reserved slots
        send_cmd(KIND_ADD, 8'd0, '0);
        send_cmd(KIND_OPEN, 8'd0, 16'h0000);
        send_cmd(KIND_OPEN, 8'hFF, 16'hFFFF);
        for (int i = RESERVED_SLOTS + 2; i < TABLE_SIZE; i++)
            send_cmd(KIND_OPEN, 8'($urandom), OH_W'($urandom));
        send_cmd(KIND_OPEN, 8'd0, OH_W'($urandom));
        send_cmd(KIND_LOOKUP, 8'd2, '0);
        send_cmd(KIND_LOOKUP, 8'(TABLE_SIZE - 1), '0);
        send_cmd(KIND_LOOKUP, 8'hFF, '0);
        send_cmd(KIND_CLOSE, 8'(TABLE_SIZE), '0);
        send_cmd(KIND_REMOVE, 8'd0, '0);
        send_cmd(KIND_REMOVE, 8'd0, '0);
        // reserved slot close and reuse
        send_cmd(KIND_CLOSE, 8'd1, '0);
        send_cmd(KIND_CLOSE, 8'd1, '0);
        send_cmd(KIND_OPEN, 8'd0, 16'hA5C3);
        send_cmd(KIND_BAD_LAST, 8'hFF, 16'hFFFF);
        send_cmd(KIND_BAD_FIRST, 8'd0, '0);

        for (int b = 0; b < 4; b++)
        begin
            idle_en = ($urandom_range(0, 2) != 0);
            for (int i = 0; i < 15; i++)
                send_random_cmd();
        end

        // no idling from here: a few users, more opens, then one more remove than add
        idle_en = 1'b0;
        for (int i = 0; i < 3; i++)
            send_cmd(KIND_ADD, 8'($urandom), OH_W'($urandom));
        for (int i = 0; i < 4; i++)
            send_cmd(KIND_OPEN, 8'($urandom), OH_W'($urandom));
        for (int i = 0; i < 4; i++)
            send_cmd(KIND_REMOVE, 8'($urandom), OH_W'($urandom));

        while (n_taken != n_sent || expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0 && expected_q.size() == 0)
            $display("handle_table_bitmap_allocator: match");
        else
            $display("handle_table_bitmap_allocator: mismatch");
        $finish;
    end

endmodule
